// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the checker modules of the animation time controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons holds at that edge.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: property failed");

// Next-cycle implication: when ante holds, cons holds at the following edge.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: property failed");

`endif

// File: hw/rtl/act_pkg.sv
// Shared types, constants and command/status structs of the animation time controller.
`timescale 1ns / 1ps
`default_nettype none
package act_pkg;

    localparam int TIME_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int PROD_W    = TIME_BITS + DATA_W;
    localparam int DIV_STEPS = DATA_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam int NUM_REGS   = 6;
    localparam int APB_ADDR_W = $clog2(NUM_REGS * 4);
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_ENABLED      = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_REPEAT_MODE  = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_MIN_TIME     = REG_IDX_W'(2);
    localparam logic [REG_IDX_W-1:0] REG_MAX_TIME     = REG_IDX_W'(3);
    localparam logic [REG_IDX_W-1:0] REG_PHASE_OFFSET = REG_IDX_W'(4);
    localparam logic [REG_IDX_W-1:0] REG_RATE_SCALE   = REG_IDX_W'(5);

    localparam logic [1:0] MODE_CLAMP  = 2'd0;
    localparam logic [1:0] MODE_WRAP   = 2'd1;
    localparam logic [1:0] MODE_MIRROR = 2'd2;

    // 1.0 in the fixed-point time format
    localparam logic [DATA_W-1:0] TIME_ONE = DATA_W'(1) << FRAC_BITS;

    typedef struct packed {
        logic              enabled;
        logic [1:0]        repeat_mode;
        logic [DATA_W-1:0] min_time;
        logic [DATA_W-1:0] max_time;
        logic [DATA_W-1:0] phase_offset;
        logic [DATA_W-1:0] rate_scale;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic acc;
        logic mag;
        logic mul;
        logic scale;
        logic phase;
        logic prep;
        logic dinit;
        logic dstep;
        logic fix;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic enabled;
        logic need_div;
    } t_sts;

endpackage
`default_nettype wire

// File: hw/rtl/animation_control_time.sv
// Top level of the animation time controller: registers, sequencer and datapath.
// Sequencing: a disabled tick goes from the input transaction straight to the output stage; an
// enabled tick passes accumulate, multiply, saturate and map, and in wrap and mirror mode with
// a non-empty interval also the 32-step restoring divider that forms the remainder.
// Throughput: one tick at a time; the next transaction is taken once the result is loaded.
// Reset (synchronous, active low) restores the register defaults and clears local time.
`timescale 1ns / 1ps
`default_nettype none
module animation_control_time import act_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0]     pwdata,
    output logic      [DATA_W-1:0]     prdata,
    output logic                       pready,
    // tick input
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [DATA_W-1:0]     i_time_step,
    // result output
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic      [DATA_W-1:0]     o_control_time,
    output logic                       o_active
);

    t_cfg cfg;
    t_cmd cmd;
    t_sts sts;

    // Register file: six control registers at word addresses, reads are combinational.
    act_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Sequencer: walks an enabled tick through accumulate, multiply, saturate, divide (wrap and
    // mirror only) and map, and owns the output valid; a finished tick holds in its last state
    // only while an earlier result still waits in the output register.
    act_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // Datapath: local time, the 32x32 multiplier, saturation, and the remainder unit.
    act_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_time_step    (i_time_step),
        .o_control_time (o_control_time),
        .o_active       (o_active)
    );

endmodule
`default_nettype wire

// File: hw/rtl/act_regs.sv
// APB configuration registers of the animation time controller.
`timescale 1ns / 1ps
`default_nettype none
module act_regs import act_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0]     pwdata,
    output logic      [DATA_W-1:0]     prdata,
    output logic                       pready,
    output t_cfg                       o_cfg
);

    t_cfg                 r_cfg;
    logic [REG_IDX_W-1:0] idx;
    logic                 wr_en;

    assign idx    = paddr[APB_ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enabled      <= 1'b0;
            r_cfg.repeat_mode  <= MODE_CLAMP;
            r_cfg.min_time     <= '0;
            r_cfg.max_time     <= TIME_ONE;
            r_cfg.phase_offset <= '0;
            r_cfg.rate_scale   <= TIME_ONE;
        end else if (wr_en) begin
            case (idx)
                REG_ENABLED:      r_cfg.enabled      <= pwdata[0];
                REG_REPEAT_MODE:  r_cfg.repeat_mode  <= pwdata[1:0];
                REG_MIN_TIME:     r_cfg.min_time     <= pwdata;
                REG_MAX_TIME:     r_cfg.max_time     <= pwdata;
                REG_PHASE_OFFSET: r_cfg.phase_offset <= pwdata;
                REG_RATE_SCALE:   r_cfg.rate_scale   <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_ENABLED:      prdata = {{(DATA_W-1){1'b0}}, r_cfg.enabled};
            REG_REPEAT_MODE:  prdata = {{(DATA_W-2){1'b0}}, r_cfg.repeat_mode};
            REG_MIN_TIME:     prdata = r_cfg.min_time;
            REG_MAX_TIME:     prdata = r_cfg.max_time;
            REG_PHASE_OFFSET: prdata = r_cfg.phase_offset;
            REG_RATE_SCALE:   prdata = r_cfg.rate_scale;
            default:          prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

// File: hw/rtl/act_ctrl.sv
// Sequencing state machine of the animation time controller.
`timescale 1ns / 1ps
`default_nettype none
module act_ctrl import act_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_stall,
    output logic      o_valid,
    input  wire logic i_stall,
    input  t_sts      i_sts,
    output t_cmd      o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_ACC, S_MAG, S_MUL, S_SCALE, S_PHASE,
        S_PREP, S_DINIT, S_DIV, S_FIX, S_DONE
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    t_cmd             cmd;

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_cmd   = cmd;

    always_comb begin
        cmd         = '0;
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_stall;
        case (r_state)
            S_IDLE: begin
                cmd.load = i_valid;
                if (i_valid) begin
                    n_state = i_sts.enabled ? S_ACC : S_DONE;
                end
            end
            S_ACC: begin
                cmd.acc = 1'b1;
                n_state = S_MAG;
            end
            S_MAG: begin
                cmd.mag = 1'b1;
                n_state = S_MUL;
            end
            S_MUL: begin
                cmd.mul = 1'b1;
                n_state = S_SCALE;
            end
            S_SCALE: begin
                cmd.scale = 1'b1;
                n_state   = S_PHASE;
            end
            S_PHASE: begin
                cmd.phase = 1'b1;
                n_state   = S_PREP;
            end
            S_PREP: begin
                cmd.prep = 1'b1;
                n_state  = S_DINIT;
            end
            S_DINIT: begin
                cmd.dinit = 1'b1;
                n_cnt     = '0;
                n_state   = i_sts.need_div ? S_DIV : S_FIX;
            end
            S_DIV: begin
                cmd.dstep = 1'b1;
                n_cnt     = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                cmd.fix = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                // wait for room in the output register
                cmd.emit = !r_out_valid || !i_stall;
                if (cmd.emit) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/act_dp.sv
// Datapath of the animation time controller: accumulate, scale, saturate, divide, map.
`timescale 1ns / 1ps
`default_nettype none
module act_dp import act_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  t_cfg                   i_cfg,
    input  t_cmd                   i_cmd,
    output t_sts                   o_sts,
    input  wire logic [DATA_W-1:0] i_time_step,
    output logic      [DATA_W-1:0] o_control_time,
    output logic                   o_active
);

    logic signed [DATA_W-1:0]    r_step;
    logic                        r_active;
    logic        [TIME_BITS-1:0] r_local;
    logic        [TIME_BITS-1:0] r_amag;
    logic        [DATA_W-1:0]    r_bmag;
    logic                        r_pneg;
    logic        [PROD_W-1:0]    r_prod;
    logic signed [DATA_W:0]      r_sprod;
    logic signed [DATA_W-1:0]    r_c;
    logic signed [DATA_W:0]      r_span;
    logic                        r_dneg;
    logic        [DATA_W-1:0]    r_dvd;
    logic        [DATA_W-1:0]    r_rem;
    logic        [DATA_W-1:0]    r_quo;
    logic        [DATA_W-1:0]    r_result;
    logic        [DATA_W-1:0]    r_out_ct;
    logic                        r_out_act;

    logic signed [DATA_W-1:0]    min_s, max_s, phase_s, rate_s;
    logic        [PROD_W-1:0]    shifted, lim, sat_mag;
    logic signed [DATA_W+1:0]    psum;
    logic signed [DATA_W:0]      diff, diff_neg;
    logic        [DATA_W:0]      shift_rem;
    logic        [DATA_W+1:0]    trial;
    logic                        need_div;
    logic        [DATA_W-1:0]    rem_fl;
    logic                        odd;
    logic        [DATA_W-1:0]    res;

    assign min_s   = i_cfg.min_time;
    assign max_s   = i_cfg.max_time;
    assign phase_s = i_cfg.phase_offset;
    assign rate_s  = i_cfg.rate_scale;

    assign need_div = (i_cfg.repeat_mode != MODE_CLAMP) && !r_span[DATA_W] && (r_span != '0);
    assign o_sts.enabled  = i_cfg.enabled;
    assign o_sts.need_div = need_div;

    // truncate the product magnitude, then saturate to the signed 32-bit range
    assign shifted = r_prod >> FRAC_BITS;
    assign lim     = r_pneg ? (PROD_W'(1) << (DATA_W - 1)) : ((PROD_W'(1) << (DATA_W - 1)) - 1'b1);
    assign sat_mag = (shifted > lim) ? lim : shifted;

    assign psum = (DATA_W+2)'(r_sprod) + (DATA_W+2)'(phase_s);

    assign diff     = (DATA_W+1)'(r_c) - (DATA_W+1)'(min_s);
    assign diff_neg = -diff;

    assign shift_rem = {r_rem, r_quo[DATA_W-1]};
    assign trial     = {1'b0, shift_rem} - {2'b00, r_span[DATA_W-1:0]};

    // floor remainder and quotient parity from the magnitude division, and the mapped result for each mode
    always_comb begin
        if (r_dneg && (r_rem != '0)) begin
            rem_fl = r_span[DATA_W-1:0] - r_rem;
            odd    = !r_quo[0];
        end else begin
            rem_fl = r_rem;
            odd    = r_quo[0];
        end
        if (i_cfg.repeat_mode == MODE_CLAMP) begin
            if (r_c < min_s) begin
                res = min_s;
            end else if (r_c > max_s) begin
                res = max_s;
            end else begin
                res = r_c;
            end
        end else if (!need_div) begin
            res = min_s;
        end else if ((i_cfg.repeat_mode != MODE_WRAP) && odd) begin
            res = max_s - rem_fl;
        end else begin
            res = min_s + rem_fl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local  <= '0;
            r_result <= '0;
        end else begin
            if (i_cmd.acc) begin
                r_local <= r_local + TIME_BITS'(r_step);
            end
            if (i_cmd.fix) begin
                r_result <= res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_step   <= i_time_step;
            r_active <= i_cfg.enabled;
        end
        if (i_cmd.mag) begin
            r_amag <= r_local[TIME_BITS-1] ? -r_local : r_local;
            r_bmag <= rate_s[DATA_W-1] ? -rate_s : rate_s;
            r_pneg <= r_local[TIME_BITS-1] ^ rate_s[DATA_W-1];
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(r_amag) * PROD_W'(r_bmag);
        end
        if (i_cmd.scale) begin
            r_sprod <= r_pneg ? -{1'b0, sat_mag[DATA_W-1:0]} : {1'b0, sat_mag[DATA_W-1:0]};
        end
        if (i_cmd.phase) begin
            // saturate when the bits above the sign disagree with it
            if (!psum[DATA_W+1] && (psum[DATA_W:DATA_W-1] != 2'b00)) begin
                r_c <= {1'b0, {(DATA_W-1){1'b1}}};
            end else if (psum[DATA_W+1] && (psum[DATA_W:DATA_W-1] != 2'b11)) begin
                r_c <= {1'b1, {(DATA_W-1){1'b0}}};
            end else begin
                r_c <= psum[DATA_W-1:0];
            end
        end
        if (i_cmd.prep) begin
            r_span <= (DATA_W+1)'(max_s) - (DATA_W+1)'(min_s);
            r_dneg <= diff[DATA_W];
            r_dvd  <= diff[DATA_W] ? diff_neg[DATA_W-1:0] : diff[DATA_W-1:0];
        end
        if (i_cmd.dinit) begin
            r_rem <= '0;
            r_quo <= r_dvd;
        end
        if (i_cmd.dstep) begin
            if (!trial[DATA_W+1]) begin
                r_rem <= trial[DATA_W-1:0];
                r_quo <= {r_quo[DATA_W-2:0], 1'b1};
            end else begin
                r_rem <= shift_rem[DATA_W-1:0];
                r_quo <= {r_quo[DATA_W-2:0], 1'b0};
            end
        end
        if (i_cmd.emit) begin
            r_out_ct  <= r_active ? r_result : '0;
            r_out_act <= r_active;
        end
    end

    assign o_control_time = r_out_ct;
    assign o_active       = r_out_act;

endmodule
`default_nettype wire

// File: hw/rtl/act_checker.sv
// Port-level checker of the animation time controller and its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module act_checker import act_pkg::*; (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_valid,
    input wire logic              o_stall,
    input wire logic              o_valid,
    input wire logic              i_stall,
    input wire logic [DATA_W-1:0] o_control_time,
    input wire logic              o_active
);

    // an inactive tick always reports zero control time
    `ASSERT_SAME(a_inactive_zero, i_clk, i_rst_n, o_valid && !o_active, o_control_time == '0)

    // a taken tick holds off the next one
    `ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, i_valid && !o_stall, o_stall)

    // a new result only appears while a tick is in progress
    `ASSERT_SAME(a_result_from_tick, i_clk, i_rst_n, $rose(o_valid), $past(o_stall))

    // a stalled result holds
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall,
        o_valid && $stable(o_control_time) && $stable(o_active))

endmodule

bind animation_control_time act_checker u_checker (.*);
`default_nettype wire
